// ===== design/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// No dependencies; the other design files except mhpq_ram refer to this package by scoped name.
package mhpq_pkg;

   localparam int CAPACITY   = 256;
   localparam int KEY_BITS   = 32;
   localparam int ID_BITS    = 16;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS   = ADDR_BITS + 2;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]         id;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // write data source
   typedef enum logic [1:0] {
      WSRC_MOV  = 2'd0,
      WSRC_RD   = 2'd1,
      WSRC_BEST = 2'd2
   } wsrc_type;

   // next slot position after a write
   typedef enum logic [1:0] {
      PSRC_HOLD   = 2'd0,
      PSRC_PARENT = 2'd1,
      PSRC_LEFT   = 2'd2,
      PSRC_RIGHT  = 2'd3
   } psrc_type;

   // read address source
   typedef enum logic [1:0] {
      RSRC_PARENT = 2'd0,
      RSRC_LEFT   = 2'd1,
      RSRC_RIGHT  = 2'd2,
      RSRC_LAST   = 2'd3
   } rsrc_type;

   typedef struct packed {
      logic     ins_start;
      logic     ext_start;
      logic     fail;
      logic     mov_from_rd;
      logic     best_take;
      logic     wr_en;
      wsrc_type wr_src;
      psrc_type pos_sel;
      rsrc_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic single;
      logic at_root;
      logic has_left;
      logic has_right;
      logic up_gt;
      logic dn_gt_l;
      logic dn_gt_r;
      logic best_child;
   } sts_type;

endpackage

// ===== design/mhpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mhpq_datapath.sv =====
// Heap datapath: entry store, moving entry, slot index, count and root cache.
// Depends on mhpq_pkg and mhpq_ram.
module mhpq_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mhpq_pkg::cmd_type                     cmd,
   output mhpq_pkg::sts_type                     sts,
   input  logic signed [mhpq_pkg::KEY_BITS-1:0]  new_key,
   input  logic [mhpq_pkg::ID_BITS-1:0]          new_id,
   output logic signed [mhpq_pkg::KEY_BITS-1:0]  removed_key,
   output logic [mhpq_pkg::ID_BITS-1:0]          removed_id,
   output logic signed [mhpq_pkg::KEY_BITS-1:0]  top_key,
   output logic [mhpq_pkg::ID_BITS-1:0]          top_id,
   output logic [mhpq_pkg::COUNT_BITS-1:0]       entry_count,
   output logic                                  empty_flag,
   output logic                                  op_error
);

   localparam int AW = mhpq_pkg::ADDR_BITS;
   localparam int CW = mhpq_pkg::COUNT_BITS;
   localparam int IW = mhpq_pkg::IDX_BITS;

   mhpq_pkg::entry_type mov_ff, mov_in;
   mhpq_pkg::entry_type best_ff, best_in;
   mhpq_pkg::entry_type top_ff, top_in;
   mhpq_pkg::entry_type rem_ff, rem_in;
   logic                best_child_ff, best_child_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                err_ff, err_in;

   mhpq_pkg::entry_type rd_ent;
   mhpq_pkg::entry_type wr_ent;
   logic [mhpq_pkg::ENTRY_BITS-1:0] rd_data;
   logic [AW-1:0]       pos_m1;
   logic [AW-1:0]       parent;
   logic [IW-1:0]       lc_w;
   logic [IW-1:0]       rc_w;
   logic [CW-1:0]       last_w;
   logic [AW-1:0]       rd_addr;

   assign rd_ent = mhpq_pkg::entry_type'(rd_data);
   assign pos_m1 = pos_ff - AW'(1);
   assign parent = pos_m1 >> 1;
   assign lc_w   = IW'({pos_ff, 1'b1});
   assign rc_w   = lc_w + IW'(1);
   assign last_w = cnt_ff - CW'(1);

   always_comb begin
      case (cmd.rd_sel)
         mhpq_pkg::RSRC_PARENT: rd_addr = parent;
         mhpq_pkg::RSRC_LEFT:   rd_addr = lc_w[AW-1:0];
         mhpq_pkg::RSRC_RIGHT:  rd_addr = rc_w[AW-1:0];
         default:               rd_addr = last_w[AW-1:0];
      endcase
   end

   always_comb begin
      case (cmd.wr_src)
         mhpq_pkg::WSRC_RD:   wr_ent = rd_ent;
         mhpq_pkg::WSRC_BEST: wr_ent = best_ff;
         default:             wr_ent = mov_ff;
      endcase
   end

   mhpq_ram #(
      .WIDTH (mhpq_pkg::ENTRY_BITS),
      .DEPTH (mhpq_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      mov_in        = mov_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      top_in        = top_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;

      if (cmd.ins_start) begin
         mov_in.key = new_key;
         mov_in.id  = new_id;
         pos_in     = cnt_ff[AW-1:0];
         cnt_in     = cnt_ff + CW'(1);
         rem_in     = '0;
         err_in     = 1'b0;
      end
      if (cmd.ext_start) begin
         rem_in = top_ff;
         cnt_in = cnt_ff - CW'(1);
         err_in = 1'b0;
      end
      if (cmd.fail) begin
         rem_in = '0;
         err_in = 1'b1;
      end
      if (cmd.mov_from_rd) begin
         mov_in = rd_ent;
         pos_in = '0;
      end
      if (cmd.best_take) begin
         best_child_in = sts.dn_gt_l;
         best_in       = sts.dn_gt_l ? rd_ent : mov_ff;
      end
      if (cmd.wr_en) begin
         if (pos_ff == '0) begin
            top_in = wr_ent;
         end
         case (cmd.pos_sel)
            mhpq_pkg::PSRC_PARENT: pos_in = parent;
            mhpq_pkg::PSRC_LEFT:   pos_in = lc_w[AW-1:0];
            mhpq_pkg::PSRC_RIGHT:  pos_in = rc_w[AW-1:0];
            default:               pos_in = pos_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mov_ff        <= mov_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      top_ff        <= top_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      err_ff        <= err_in;
   end

   assign sts.full       = (cnt_ff == CW'(mhpq_pkg::CAPACITY));
   assign sts.empty      = (cnt_ff == '0);
   assign sts.single     = (cnt_ff == CW'(1));
   assign sts.at_root    = (pos_ff == '0);
   assign sts.has_left   = (lc_w < IW'(cnt_ff));
   assign sts.has_right  = (rc_w < IW'(cnt_ff));
   assign sts.up_gt      = (rd_ent.key > mov_ff.key);
   assign sts.dn_gt_l    = (mov_ff.key > rd_ent.key);
   assign sts.dn_gt_r    = (best_ff.key > rd_ent.key);
   assign sts.best_child = best_child_ff;

   assign removed_key = rem_ff.key;
   assign removed_id  = rem_ff.id;
   assign top_key     = sts.empty ? '0 : top_ff.key;
   assign top_id      = sts.empty ? '0 : top_ff.id;
   assign entry_count = cnt_ff;
   assign empty_flag  = sts.empty;
   assign op_error    = err_ff;

endmodule

// ===== design/mhpq_ctrl.sv =====
// Sequencer for insert (sift-up) and extract (sift-down) operations.
// Depends on mhpq_pkg; drives mhpq_datapath through cmd_type / sts_type.
module mhpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mhpq_pkg::cmd_type cmd,
   input  mhpq_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_UP       = 8'b0000_0010,
      ST_UP_CMP   = 8'b0000_0100,
      ST_DN_LAST  = 8'b0000_1000,
      ST_DN_CHK   = 8'b0001_0000,
      ST_DN_LEFT  = 8'b0010_0000,
      ST_DN_RIGHT = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      start_ok;

   assign start_ok  = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign req_ready = start_ok;
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_UP: begin
            if (sts.at_root) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = mhpq_pkg::WSRC_MOV;
               state_in   = ST_RESP;
            end else begin
               cmd.rd_sel = mhpq_pkg::RSRC_PARENT;
               state_in   = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.up_gt) begin
               cmd.wr_src  = mhpq_pkg::WSRC_RD;
               cmd.pos_sel = mhpq_pkg::PSRC_PARENT;
               state_in    = ST_UP;
            end else begin
               cmd.wr_src = mhpq_pkg::WSRC_MOV;
               state_in   = ST_RESP;
            end
         end
         ST_DN_LAST: begin
            cmd.mov_from_rd = 1'b1;
            state_in        = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (sts.has_left) begin
               cmd.rd_sel = mhpq_pkg::RSRC_LEFT;
               state_in   = ST_DN_LEFT;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = mhpq_pkg::WSRC_MOV;
               state_in   = ST_RESP;
            end
         end
         ST_DN_LEFT: begin
            if (sts.has_right) begin
               cmd.best_take = 1'b1;
               cmd.rd_sel    = mhpq_pkg::RSRC_RIGHT;
               state_in      = ST_DN_RIGHT;
            end else if (sts.dn_gt_l) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_src  = mhpq_pkg::WSRC_RD;
               cmd.pos_sel = mhpq_pkg::PSRC_LEFT;
               state_in    = ST_DN_CHK;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_src = mhpq_pkg::WSRC_MOV;
               state_in   = ST_RESP;
            end
         end
         ST_DN_RIGHT: begin
            cmd.wr_en = 1'b1;
            if (sts.dn_gt_r) begin
               cmd.wr_src  = mhpq_pkg::WSRC_RD;
               cmd.pos_sel = mhpq_pkg::PSRC_RIGHT;
               state_in    = ST_DN_CHK;
            end else if (sts.best_child) begin
               cmd.wr_src  = mhpq_pkg::WSRC_BEST;
               cmd.pos_sel = mhpq_pkg::PSRC_LEFT;
               state_in    = ST_DN_CHK;
            end else begin
               cmd.wr_src = mhpq_pkg::WSRC_MOV;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new item, taken from idle or in the cycle the last result transfers
      if (start_ok && req_valid) begin
         if (req_kind == mhpq_pkg::KIND_INSERT) begin
            if (sts.full) begin
               cmd.fail = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = ST_UP;
            end
         end else begin
            if (sts.empty) begin
               cmd.fail = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.ext_start = 1'b1;
               cmd.rd_sel    = mhpq_pkg::RSRC_LAST;
               state_in      = sts.single ? ST_RESP : ST_DN_LAST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/min_heap_priority_queue.sv =====
// Binary min-heap priority queue, one item in flight at a time.
// An insert sifts up towards the root and an extract sifts down; the store's single read port
// serves one read per sift step.
// A new item is taken while idle or in the cycle the previous result transfers.
// Reset (synchronous, active high) empties the heap; store contents are not cleared.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath, mhpq_ram.
module min_heap_priority_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [mhpq_pkg::KEY_BITS-1:0]  req_new_key,
   input  logic [mhpq_pkg::ID_BITS-1:0]          req_new_id,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mhpq_pkg::KEY_BITS-1:0]  rsp_removed_key,
   output logic [mhpq_pkg::ID_BITS-1:0]          rsp_removed_id,
   output logic signed [mhpq_pkg::KEY_BITS-1:0]  rsp_top_key,
   output logic [mhpq_pkg::ID_BITS-1:0]          rsp_top_id,
   output logic [mhpq_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   output logic                                  rsp_empty_flag,
   output logic                                  rsp_op_error
);

   // Controller sequences the sift; datapath holds the store and the moving
   // entry. The entry being sifted is kept in a register and only written
   // once its final slot is known; children/parents move into the hole.
   mhpq_pkg::cmd_type cmd;
   mhpq_pkg::sts_type sts;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Response fields are straight from registers that hold still while
   // rsp_valid is high; the root is cached so top is always on hand.
   mhpq_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .new_key     (req_new_key),
      .new_id      (req_new_id),
      .removed_key (rsp_removed_key),
      .removed_id  (rsp_removed_id),
      .top_key     (rsp_top_key),
      .top_id      (rsp_top_id),
      .entry_count (rsp_entry_count),
      .empty_flag  (rsp_empty_flag),
      .op_error    (rsp_op_error)
   );

endmodule

// ===== design/mhpq_checker.sv =====
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
module mhpq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [mhpq_pkg::KEY_BITS-1:0]  rsp_removed_key,
   input logic [mhpq_pkg::ID_BITS-1:0]          rsp_removed_id,
   input logic signed [mhpq_pkg::KEY_BITS-1:0]  rsp_top_key,
   input logic [mhpq_pkg::ID_BITS-1:0]          rsp_top_id,
   input logic [mhpq_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   input logic                                  rsp_empty_flag,
   input logic                                  rsp_op_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("response dropped or count changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> (rsp_top_key == '0) && (rsp_top_id == '0))
      else $error("top not zero on empty heap");

   a_err_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_error |-> (rsp_removed_key == '0) && (rsp_removed_id == '0))
      else $error("refused operation reported a removed entry");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= mhpq_pkg::COUNT_BITS'(mhpq_pkg::CAPACITY)))
      else $error("count beyond capacity");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_removed_key (rsp_removed_key),
   .rsp_removed_id  (rsp_removed_id),
   .rsp_top_key     (rsp_top_key),
   .rsp_top_id      (rsp_top_id),
   .rsp_entry_count (rsp_entry_count),
   .rsp_empty_flag  (rsp_empty_flag),
   .rsp_op_error    (rsp_op_error)
);

// ===== dv/min_heap_priority_queue_tb.sv =====
// Self-checking testbench for min_heap_priority_queue: inserts and extracts against a heap image.
// Depends on mhpq_pkg and the design files; the driver and the monitor are clocked always blocks.
`timescale 1ns / 100ps

module min_heap_priority_queue_tb;

   localparam int   CAPACITY     = mhpq_pkg::CAPACITY;
   localparam int   KEY_BITS     = mhpq_pkg::KEY_BITS;
   localparam int   ID_BITS      = mhpq_pkg::ID_BITS;
   localparam int   COUNT_BITS   = mhpq_pkg::COUNT_BITS;
   localparam logic KIND_INSERT  = mhpq_pkg::KIND_INSERT;
   localparam logic KIND_EXTRACT = mhpq_pkg::KIND_EXTRACT;

   // one pending operation for the request channel
   typedef struct {
      logic                       kind;
      logic signed [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]         id;
   } heap_op_type;

   // what one response transfer should carry
   typedef struct {
      logic signed [KEY_BITS-1:0] removed_key;
      logic [ID_BITS-1:0]         removed_id;
      logic signed [KEY_BITS-1:0] top_key;
      logic [ID_BITS-1:0]         top_id;
      logic [COUNT_BITS-1:0]      entry_count;
      logic                       empty_flag;
      logic                       op_error;
   } heap_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = KIND_INSERT;
   logic signed [KEY_BITS-1:0]  req_new_key = '0;
   logic [ID_BITS-1:0]          req_new_id = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [KEY_BITS-1:0]  rsp_removed_key;
   logic [ID_BITS-1:0]          rsp_removed_id;
   logic signed [KEY_BITS-1:0]  rsp_top_key;
   logic [ID_BITS-1:0]          rsp_top_id;
   logic [COUNT_BITS-1:0]       rsp_entry_count;
   logic                        rsp_empty_flag;
   logic                        rsp_op_error;

   min_heap_priority_queue dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_new_key     (req_new_key),
      .req_new_id      (req_new_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_removed_key (rsp_removed_key),
      .rsp_removed_id  (rsp_removed_id),
      .rsp_top_key     (rsp_top_key),
      .rsp_top_id      (rsp_top_id),
      .rsp_entry_count (rsp_entry_count),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_op_error    (rsp_op_error)
   );

   // 2 ns period
   always #1 clock = ~clock;

   // stimulus still to be offered, and responses still owed by the block
   heap_op_type     pending_ops [$];
   heap_result_type owed_results [$];

   // idle percentages, changed only at rising edges by the sequence below
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // set at each rising edge when the request on the bus transferred
   logic req_taken = 1'b0;

   // heap image kept alongside the block
   mhpq_pkg::entry_type heap_image [CAPACITY];
   int unsigned         heap_fill = 0;

   // occupancy as seen by the generator, so sequences can aim for full and empty
   int unsigned gen_fill = 0;

   int unsigned mismatch_count = 0;
   int unsigned orphan_count   = 0;
   int unsigned rsp_seen       = 0;
   int unsigned insert_count   = 0;
   int unsigned extract_count  = 0;
   int unsigned refused_count  = 0;
   int unsigned peak_fill      = 0;

   function automatic void swap_entries(input int unsigned a, input int unsigned b);
      mhpq_pkg::entry_type t;
      t             = heap_image[a];
      heap_image[a] = heap_image[b];
      heap_image[b] = t;
   endfunction

   // Applies one operation to the heap image and returns the response it should produce.
   function automatic heap_result_type apply_heap_op(input logic kind,
                                                     input logic signed [KEY_BITS-1:0] key,
                                                     input logic [ID_BITS-1:0] id);
      heap_result_type res;
      int unsigned     pos;
      int unsigned     up;
      int unsigned     best;
      int unsigned     lc;
      int unsigned     rc;
      res = '{default: '0};
      if (kind == KIND_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            res.op_error = 1'b1;
         end else begin
            heap_image[heap_fill].key = key;
            heap_image[heap_fill].id  = id;
            pos = heap_fill;
            heap_fill++;
            // climb while the parent is strictly greater; an equal parent stops it
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!($signed(heap_image[up].key) > $signed(heap_image[pos].key))) break;
               swap_entries(up, pos);
               pos = up;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.op_error = 1'b1;
         end else begin
            res.removed_key = heap_image[0].key;
            res.removed_id  = heap_image[0].id;
            heap_fill--;
            if (heap_fill > 0) begin
               heap_image[0] = heap_image[heap_fill];
               pos = 0;
               // sink towards the smaller child, left on ties, only past a strictly smaller one
               forever begin
                  best = pos;
                  lc   = 2 * pos + 1;
                  rc   = 2 * pos + 2;
                  if (lc < heap_fill &&
                      $signed(heap_image[best].key) > $signed(heap_image[lc].key)) best = lc;
                  if (rc < heap_fill &&
                      $signed(heap_image[best].key) > $signed(heap_image[rc].key)) best = rc;
                  if (best == pos) break;
                  swap_entries(pos, best);
                  pos = best;
               end
            end
         end
      end
      if (heap_fill > 0) begin
         res.top_key = heap_image[0].key;
         res.top_id  = heap_image[0].id;
      end
      res.entry_count = heap_fill[COUNT_BITS-1:0];
      res.empty_flag  = (heap_fill == 0);
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [KEY_BITS-1:0] want,
                                input logic [KEY_BITS-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] response %0d, %s: expected %0h, got %0h",
                     $realtime, rsp_seen, field, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: payload and valid change on the falling edge. A new item goes out only once the
   // previous one has transferred, so valid and payload hold steady while the block stalls.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      heap_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_valid || req_taken) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_kind    <= op.kind;
               req_new_key <= op.key;
               req_new_id  <= op.id;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge. A response transfer is checked against
   // the oldest owed result before a request transferring at the same edge is predicted.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      heap_result_type want;
      heap_result_type next_res;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               orphan_count++;
               if (orphan_count <= 10)
                  $display("[%0t] response transfer with nothing owed", $realtime);
            end else begin
               want = owed_results.pop_front();
               compare_field("removed_key", want.removed_key, rsp_removed_key);
               compare_field("removed_id",  KEY_BITS'(want.removed_id), KEY_BITS'(rsp_removed_id));
               compare_field("top_key",     want.top_key, rsp_top_key);
               compare_field("top_id",      KEY_BITS'(want.top_id), KEY_BITS'(rsp_top_id));
               compare_field("entry_count", KEY_BITS'(want.entry_count),
                             KEY_BITS'(rsp_entry_count));
               compare_field("empty_flag",  KEY_BITS'(want.empty_flag),
                             KEY_BITS'(rsp_empty_flag));
               compare_field("op_error",    KEY_BITS'(want.op_error), KEY_BITS'(rsp_op_error));
               rsp_seen++;
            end
         end
         if (req_valid && req_ready) begin
            next_res = apply_heap_op(req_kind, req_new_key, req_new_id);
            owed_results.insert(owed_results.size(), next_res);
            if (req_kind == KIND_INSERT) insert_count++;
            else extract_count++;
            if (next_res.op_error) refused_count++;
            if (heap_fill > peak_fill) peak_fill = heap_fill;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   // Keys: heavy on the two extremes and on a narrow band so that equal keys are common.
   function automatic logic signed [KEY_BITS-1:0] pick_key();
      logic signed [KEY_BITS-1:0] k;
      case ($urandom_range(9)) inside
         0:       k = {1'b1, {(KEY_BITS-1){1'b0}}};
         1:       k = {1'b0, {(KEY_BITS-1){1'b1}}};
         [2:4]:   k = KEY_BITS'($urandom_range(7)) - KEY_BITS'(4);
         default: k = $urandom;
      endcase
      return k;
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id();
      logic [ID_BITS-1:0] v;
      case ($urandom_range(7))
         0:       v = '0;
         1:       v = '1;
         default: v = ID_BITS'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_op(input logic kind, input logic signed [KEY_BITS-1:0] key,
                           input logic [ID_BITS-1:0] id);
      heap_op_type op;
      op.kind = kind;
      op.key  = key;
      op.id   = id;
      pending_ops.insert(pending_ops.size(), op);
      if (kind == KIND_INSERT && gen_fill < CAPACITY) gen_fill++;
      else if (kind == KIND_EXTRACT && gen_fill > 0) gen_fill--;
   endtask

   // extracts carry random payload too; the block must ignore it
   task automatic queue_random(input int unsigned insert_pct);
      if ($urandom_range(99) < insert_pct) queue_op(KIND_INSERT, pick_key(), pick_id());
      else queue_op(KIND_EXTRACT, pick_key(), pick_id());
   endtask

   task automatic queue_mixed(input int unsigned n);
      repeat (n) queue_random(gen_fill < 8 ? 75 : 50);
   endtask

   // wait until nothing is queued, on the bus or owed
   task automatic drain_all();
      while (pending_ops.size() != 0 || req_valid || owed_results.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: slow sender, very slow receiver
      send_idle_pct = 30;
      recv_idle_pct = 88;

      // directed: underflow, single entry in and out, extremes, equal keys, then drain past empty
      queue_op(KIND_EXTRACT, '0, '0);
      queue_op(KIND_INSERT, '0, '0);
      queue_op(KIND_EXTRACT, '1, '1);
      queue_op(KIND_EXTRACT, '0, '0);
      queue_op(KIND_INSERT, {1'b0, {(KEY_BITS-1){1'b1}}}, '1);
      queue_op(KIND_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, ID_BITS'(1));
      queue_op(KIND_INSERT, '1, ID_BITS'(16'h5555));
      queue_op(KIND_INSERT, KEY_BITS'(1), ID_BITS'(16'haaaa));
      queue_op(KIND_INSERT, KEY_BITS'(5), ID_BITS'(10));
      queue_op(KIND_INSERT, KEY_BITS'(5), ID_BITS'(11));
      queue_op(KIND_INSERT, KEY_BITS'(5), ID_BITS'(12));
      // same key as the current root: must settle below it
      queue_op(KIND_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, ID_BITS'(2));
      repeat (10) queue_op(KIND_EXTRACT, '0, '0);
      drain_all();

      queue_mixed(80);
      drain_all();

      // phase two: the other way round
      send_idle_pct = 88;
      recv_idle_pct = 30;
      queue_mixed(80);
      drain_all();

      // phase three: no idling; mixed traffic, then fill to capacity, overflow, drain, underflow
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_mixed(40);
      while (gen_fill < CAPACITY) queue_random(90);
      repeat (3) queue_op(KIND_INSERT, pick_key(), pick_id());
      queue_op(KIND_EXTRACT, pick_key(), pick_id());
      repeat (2) queue_op(KIND_INSERT, pick_key(), pick_id());
      while (gen_fill > 0) queue_random(10);
      repeat (2) queue_op(KIND_EXTRACT, pick_key(), pick_id());
      drain_all();

      // allow for stragglers
      repeat (40) @(posedge clock);

      $display("%0d transfers in: %0d inserts, %0d extracts, %0d refused; peak fill %0d of %0d",
               insert_count + extract_count, insert_count, extract_count, refused_count,
               peak_fill, CAPACITY);
      $display("%0d responses checked, %0d field mismatches, %0d unexpected, %0d still owed",
               rsp_seen, mismatch_count, orphan_count, owed_results.size());
      if (mismatch_count == 0 && orphan_count == 0 && owed_results.size() == 0) begin
         $display("min_heap_priority_queue_tb passed");
      end else begin
         $display("min_heap_priority_queue_tb failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout: %0d responses checked, %0d still owed", rsp_seen, owed_results.size());
      $display("min_heap_priority_queue_tb failed");
      $finish;
   end

endmodule
